[rtl/btm_pkg.sv]
// btm_pkg: types and constants shared by the breakpoint table manager
// request and response payloads, command and status structs, controller states
// no dependencies
`default_nettype none

package btm_pkg;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned KEY_W  = 29;
   localparam int unsigned CODE_W = 16;
   localparam int unsigned CSR_W  = 32;

   localparam logic [1:0] MODE_SET        = 2'd0;
   localparam logic [1:0] MODE_CLEAR      = 2'd1;
   localparam logic [1:0] MODE_QUERY      = 2'd2;
   localparam logic [1:0] MODE_QUERY_ALT  = 2'd3;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_MISS        = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

   localparam logic CSR_WINDOW_LOW  = 1'b0;
   localparam logic CSR_WINDOW_HIGH = 1'b1;

   localparam logic [CSR_W-1:0]  WINDOW_LOW_RESET  = 32'h0000_0000;
   localparam logic [CSR_W-1:0]  WINDOW_HIGH_RESET = 32'h5FFF_FFFF;
   localparam logic [KEY_W-1:0]  ADDR_MASK         = 29'h1FFF_FFFE;
   localparam logic [CODE_W-1:0] TRAP_CODE         = 16'hDF10;
   localparam logic [ADDR_W-1:0] FLAG_COUNT        = 32'd15;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] address;
      logic [CODE_W-1:0] original_code;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              hit;
      logic              write_enable;
      logic [KEY_W-1:0]  write_address;
      logic [CODE_W-1:0] write_data;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan;
      logic fetch;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic in_window;
      logic scan_done;
      logic out_free;
   } stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FETCH,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[rtl/btm_ctrl.sv]
// btm_ctrl: controller state machine of the breakpoint table manager
// sequences decode, slot scan, saved code fetch and response load
// depends on btm_pkg
`default_nettype none

module btm_ctrl
   import btm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_stall,
   input  wire stat_type stat,
   output      cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = stat.in_window ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_DECODE: begin
            cmd.scan_start = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/btm_datapath.sv]
// btm_datapath: request register, window registers, slot tables, flags and response register
// scans the slot table one entry per cycle under control of btm_ctrl
// depends on btm_pkg
`default_nettype none

module btm_datapath
   import btm_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 32
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_payload,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic [CSR_W-1:0] csr_write_data,
   input  wire logic       rsp_stall,
   output      logic       rsp_valid,
   output      rsp_type    rsp_payload,
   input  wire cmd_type    cmd,
   output      stat_type   stat
);

   localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(TABLE_SLOTS);

   req_type            req_ff;
   logic [CSR_W-1:0]   win_low_ff;
   logic [CSR_W-1:0]   win_high_ff;

   logic [KEY_W-1:0]   slot_addr_ff [TABLE_SLOTS];
   logic [CODE_W-1:0]  slot_code_ff [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] slot_valid_ff;

   logic [CNT_W-1:0]   rd_idx_ff;
   logic               cmp_pending_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic [KEY_W-1:0]   rd_addr_ff;
   logic               rd_valid_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   found_idx_ff;
   logic [CODE_W-1:0]  code_rd_ff;

   logic [FLAG_COUNT-1:0] flag_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [KEY_W-1:0]   key;
   logic [KEY_W-1:0]   target;
   logic [KEY_W-1:0]   entry;
   logic               in_window;
   logic               in_flags;
   logic               rd_more;
   logic               match;
   logic               scan_done;
   logic               out_free;
   logic               commit_set;
   logic               commit_clear;
   logic [3:0]         flag_idx;

   assign key       = req_ff.address[KEY_W-1:0] & ADDR_MASK;
   assign target    = (req_ff.mode == MODE_SET) ? '0 : key;
   assign in_window = (req_ff.address >= win_low_ff) && (req_ff.address <= win_high_ff);
   assign in_flags  = req_ff.address < FLAG_COUNT;
   assign flag_idx  = req_ff.address[3:0];
   assign rd_more   = rd_idx_ff < SLOT_COUNT;
   assign entry     = rd_valid_ff ? rd_addr_ff : '0;
   assign match     = cmp_pending_ff && (entry == target);
   assign scan_done = match || (!cmp_pending_ff && !rd_more);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign commit_set   = cmd.finish && in_window && (req_ff.mode == MODE_SET) && found_ff;
   assign commit_clear = cmd.finish && in_window && (req_ff.mode == MODE_CLEAR) && found_ff;

   assign stat.in_window = in_window;
   assign stat.scan_done = scan_done;
   assign stat.out_free  = out_free;

   // request and window registers
   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_payload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff  <= WINDOW_LOW_RESET;
         win_high_ff <= WINDOW_HIGH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_LOW:  win_low_ff  <= csr_write_data;
            CSR_WINDOW_HIGH: win_high_ff <= csr_write_data;
            default: begin
               win_low_ff <= win_low_ff;
            end
         endcase
      end
   end

   // scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff      <= '0;
         cmp_pending_ff <= 1'b0;
         found_ff       <= 1'b0;
      end else if (cmd.scan_start) begin
         rd_idx_ff      <= '0;
         cmp_pending_ff <= 1'b0;
         found_ff       <= 1'b0;
      end else if (cmd.scan) begin
         if (rd_more) rd_idx_ff <= rd_idx_ff + 1'b1;
         cmp_pending_ff <= rd_more;
         if (scan_done) found_ff <= match;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
         if (scan_done) found_idx_ff <= cmp_idx_ff;
      end
   end

   // slot tables
   always_ff @(posedge clock) begin
      if (cmd.scan && rd_more) begin
         rd_addr_ff  <= slot_addr_ff[rd_idx_ff[IDX_W-1:0]];
         rd_valid_ff <= slot_valid_ff[rd_idx_ff[IDX_W-1:0]];
      end
      if (commit_set) begin
         slot_addr_ff[found_idx_ff] <= key;
         slot_code_ff[found_idx_ff] <= req_ff.original_code;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) code_rd_ff <= slot_code_ff[found_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (commit_set) begin
         slot_valid_ff[found_idx_ff] <= 1'b1;
      end else if (commit_clear) begin
         slot_valid_ff[found_idx_ff] <= 1'b0;
      end
   end

   // enable flags
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else if (cmd.finish && !in_window && in_flags) begin
         case (req_ff.mode)
            MODE_SET:   flag_ff[flag_idx] <= 1'b1;
            MODE_CLEAR: flag_ff[flag_idx] <= 1'b0;
            default: begin
               flag_ff <= flag_ff;
            end
         endcase
      end
   end

   // response
   always_comb begin
      rsp_in = '0;
      if (in_window) begin
         case (req_ff.mode)
            MODE_SET: begin
               if (found_ff) begin
                  rsp_in.write_enable  = 1'b1;
                  rsp_in.write_address = key;
                  rsp_in.write_data    = TRAP_CODE;
               end else begin
                  rsp_in.status = STATUS_MISS;
               end
            end
            MODE_CLEAR: begin
               if (found_ff) begin
                  rsp_in.write_enable  = 1'b1;
                  rsp_in.write_address = key;
                  rsp_in.write_data    = code_rd_ff;
               end else begin
                  rsp_in.status = STATUS_MISS;
               end
            end
            default: begin
               rsp_in.hit = found_ff;
            end
         endcase
      end else if (in_flags) begin
         if (req_ff.mode inside {MODE_QUERY, MODE_QUERY_ALT}) begin
            rsp_in.hit = flag_ff[flag_idx];
         end
      end else begin
         rsp_in.status = STATUS_UNSUPPORTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/breakpoint_table_manager.sv]
// breakpoint_table_manager: top level, joins btm_ctrl and btm_datapath
// depends on btm_pkg, btm_ctrl, btm_datapath
//
//   port group  direction  handshake            carries
//   req_        in         req_valid/req_stall  mode, address, original_code
//   rsp_        out        rsp_valid/rsp_stall  status, hit, write_enable/address/data
//   csr_        in         csr_write_enable     window low (0) and high (1)
//
// one request at a time; a request in the window passes decode, a scan at one slot
// table read per cycle, saved code fetch and finish; others pass decode and finish
// the next request can already be taken while the response is shown and waits
// reset is synchronous and frees every slot and clears every flag
// rsp_stall holds only the finish step; csr writes are taken at any cycle
`default_nettype none

module breakpoint_table_manager
   import btm_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 32
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire req_type          req_payload,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      rsp_type          rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   btm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   btm_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

`default_nettype wire

[rtl/btm_checker.sv]
// btm_checker: port level assertions for breakpoint_table_manager
// bound to the top level; depends on btm_pkg
`default_nettype none

module btm_checker
   import btm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.write_enable |->
         rsp_payload.status == STATUS_OK && !rsp_payload.hit)
      else $error("patch request with error status or hit");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.write_enable |->
         rsp_payload.write_address == '0 && rsp_payload.write_data == '0)
      else $error("write fields set without a patch");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |-> !rsp_payload.hit)
      else $error("hit with error status");

endmodule

bind breakpoint_table_manager btm_checker u_checker (.*);

`default_nettype wire

[tb/sv/breakpoint_table_checker.sv]
// breakpoint_table_checker: watches the request, response and csr ports of the
// breakpoint table manager, predicts each response and compares it field by field
// depends on btm_pkg
module breakpoint_table_checker
   import btm_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 32
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire req_type          req_payload,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire rsp_type          rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_write_data,
   output int                    mismatches,
   output int                    outstanding,
   output logic                  zero_clear_safe
);

   logic [KEY_W-1:0]  slot_key        [TABLE_SLOTS];
   logic [CODE_W-1:0] slot_code       [TABLE_SLOTS];
   logic              slot_code_known [TABLE_SLOTS];
   logic              flag_on         [15];
   logic [CSR_W-1:0]  win_low;
   logic [CSR_W-1:0]  win_high;
   rsp_type           replies_due [$];
   rsp_type           want;
   rsp_type           got;

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      zero_clear_safe = 1'b1;
   end

   function automatic int lowest_slot(input logic [KEY_W-1:0] key);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_key[i] == key) return i;
      end
      return -1;
   endfunction

   // clearing a zero key reads the lowest free slot, which must hold a saved code
   function automatic logic free_slot_code_known();
      int s;
      s = lowest_slot('0);
      return (s < 0) || slot_code_known[s];
   endfunction

   function automatic rsp_type apply_breakpoint_op(input req_type r);
      rsp_type          a;
      logic [KEY_W-1:0] key;
      int               s;
      a   = '0;
      key = r.address[KEY_W-1:0] & ADDR_MASK;
      if (r.address >= win_low && r.address <= win_high) begin
         if (r.mode[1]) begin
            a.hit = (lowest_slot(key) >= 0);
         end else if (r.mode == MODE_SET) begin
            s = lowest_slot('0);
            if (s < 0) begin
               a.status = STATUS_MISS;
            end else begin
               slot_key[s]        = key;
               slot_code[s]       = r.original_code;
               slot_code_known[s] = 1'b1;
               a.write_enable     = 1'b1;
               a.write_address    = key;
               a.write_data       = TRAP_CODE;
            end
         end else begin
            s = lowest_slot(key);
            if (s < 0) begin
               a.status = STATUS_MISS;
            end else begin
               slot_key[s]     = '0;
               a.write_enable  = 1'b1;
               a.write_address = key;
               a.write_data    = slot_code[s];
            end
         end
      end else if (r.address < FLAG_COUNT) begin
         if (r.mode[1]) begin
            a.hit = flag_on[r.address[3:0]];
         end else if (r.mode == MODE_SET) begin
            flag_on[r.address[3:0]] = 1'b1;
         end else begin
            flag_on[r.address[3:0]] = 1'b0;
         end
      end else begin
         a.status = STATUS_UNSUPPORTED;
      end
      return a;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_key[i]        = '0;
            slot_code[i]       = '0;
            slot_code_known[i] = 1'b0;
         end
         for (int i = 0; i < 15; i++) flag_on[i] = 1'b0;
         win_low  = WINDOW_LOW_RESET;
         win_high = WINDOW_HIGH_RESET;
         replies_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with none awaited: status %0d hit %0d we %0d addr %h data %h",
                           $time, got.status, got.hit, got.write_enable,
                           got.write_address, got.write_data);
            end else begin
               want = replies_due.pop_front();
               if (got.status !== want.status || got.hit !== want.hit
                   || got.write_enable !== want.write_enable
                   || got.write_address !== want.write_address
                   || got.write_data !== want.write_data) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: expected status %0d hit %0d we %0d addr %h data %h",
                              $time, want.status, want.hit, want.write_enable,
                              want.write_address, want.write_data);
                     $display("%0t: actual   status %0d hit %0d we %0d addr %h data %h",
                              $time, got.status, got.hit, got.write_enable,
                              got.write_address, got.write_data);
                  end
               end
            end
         end
         if (req_valid && !req_stall) replies_due.push_back(apply_breakpoint_op(req_payload));
         if (csr_write_enable) begin
            if (csr_index == CSR_WINDOW_LOW) win_low = csr_write_data;
            else win_high = csr_write_data;
         end
      end
      outstanding     = replies_due.size();
      zero_clear_safe = free_slot_code_known();
   end

endmodule

[tb/sv/tb_breakpoint_table_manager.sv]
// tb_breakpoint_table_manager: stimulus, response stall patterns and verdict for the
// breakpoint table manager; checking is done by breakpoint_table_checker
// depends on btm_pkg, breakpoint_table_manager, breakpoint_table_checker
module tb_breakpoint_table_manager;
   import btm_pkg::*;

   localparam int unsigned SLOTS         = 32;
   localparam int          SETTLE_CYCLES = SLOTS + 8;
   localparam int          IDLE_LIMIT    = 3000;
   localparam int          POOL_DEPTH    = 64;

   typedef enum int {TRAFFIC_MIXED, TRAFFIC_FILL, TRAFFIC_DRAIN} traffic_type;
   typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LONG} stall_style_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_write_enable;
   logic             csr_index;
   logic [CSR_W-1:0] csr_write_data;

   int               mismatches;
   int               outstanding;
   logic             zero_clear_safe;

   logic [CSR_W-1:0]  win_low;
   logic [CSR_W-1:0]  win_high;
   logic [ADDR_W-1:0] set_addresses [$];
   req_type           fixed_q [$];
   traffic_type       traffic;
   int                idle_cycles = 0;
   int unsigned       stall_tick  = 0;
   int unsigned       stall_hold  = 0;
   stall_style_type   stall_style = STALL_NONE;

   breakpoint_table_manager #(.TABLE_SLOTS(SLOTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   breakpoint_table_checker #(.TABLE_SLOTS(SLOTS)) monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .zero_clear_safe  (zero_clear_safe)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // receiver stall pattern, with a style that is redrawn at random from time to time
   always @(negedge clock) begin
      if (stall_tick % 96 == 0) stall_style = stall_style_type'($urandom_range(0, 3));
      stall_tick++;
      case (stall_style)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_COIN: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         STALL_PERIODIC: begin
            rsp_stall <= (stall_tick % 5) < 2;
         end
         default: begin
            if (stall_hold == 0 && $urandom_range(0, 15) == 0) stall_hold = $urandom_range(5, 30);
            rsp_stall <= (stall_hold != 0);
            if (stall_hold != 0) stall_hold--;
         end
      endcase
   end

   function automatic logic in_window(input logic [ADDR_W-1:0] a);
      return a >= win_low && a <= win_high;
   endfunction

   function automatic logic [ADDR_W-1:0] window_address();
      if (win_low <= win_high) return $urandom_range(win_high, win_low);
      return $urandom;
   endfunction

   function automatic req_type req_of(input logic [1:0] m, input logic [ADDR_W-1:0] a,
                                      input logic [CODE_W-1:0] c);
      req_type r;
      r.mode          = m;
      r.address       = a;
      r.original_code = c;
      return r;
   endfunction

   function automatic void remember(input logic [ADDR_W-1:0] a);
      if (set_addresses.size() < POOL_DEPTH) set_addresses.push_back(a);
   endfunction

   function automatic req_type next_request();
      req_type r;
      int      pick;
      int      idx;
      r.mode          = 2'($urandom_range(MODE_SET, MODE_QUERY_ALT));
      r.address       = $urandom;
      r.original_code = 16'($urandom);
      pick            = $urandom_range(0, 99);
      if (traffic == TRAFFIC_FILL) begin
         r.mode    = MODE_SET;
         r.address = window_address();
         remember(r.address);
      end else if (traffic == TRAFFIC_DRAIN) begin
         r.mode = MODE_CLEAR;
         if (set_addresses.size() != 0) r.address = set_addresses.pop_front();
      end else if (pick < 30 || (pick < 65 && set_addresses.size() == 0)) begin
         r.mode    = MODE_SET;
         r.address = window_address();
         if (in_window(r.address)) remember(r.address);
      end else if (pick < 50) begin
         idx       = $urandom_range(0, set_addresses.size() - 1);
         r.mode    = MODE_CLEAR;
         r.address = set_addresses[idx];
         set_addresses.delete(idx);
         if ($urandom_range(0, 1) && in_window(r.address ^ 32'd1)) r.address ^= 32'd1;
      end else if (pick < 65) begin
         idx       = $urandom_range(0, set_addresses.size() - 1);
         r.mode    = $urandom_range(0, 1) ? MODE_QUERY : MODE_QUERY_ALT;
         r.address = $urandom_range(0, 3) == 0 ? window_address() : set_addresses[idx];
      end else if (pick < 75) begin
         r.address = $urandom_range(0, FLAG_COUNT - 1);
      end else if (pick < 85) begin
         r.address = $urandom;
      end else if (pick < 90) begin
         // addresses whose masked key is zero
         r.address = $urandom & 32'hE000_0001;
      end else begin
         case ($urandom_range(0, 3))
            0:       r.address = win_low;
            1:       r.address = win_high;
            2:       r.address = win_low - 1;
            default: r.address = win_high + 1;
         endcase
      end
      return r;
   endfunction

   task automatic pump(input int count);
      int      burst;
      int      gap;
      req_type r;
      while (count > 0) begin
         burst = $urandom_range(0, 4) == 0 ? $urandom_range(12, 30) : $urandom_range(1, 8);
         for (int k = 0; k < burst && count > 0; k++) begin
            @(negedge clock);
            if (fixed_q.size() != 0) r = fixed_q.pop_front();
            else r = next_request();
            if (r.mode == MODE_CLEAR && in_window(r.address) && !zero_clear_safe
                && (r.address & {3'b000, ADDR_MASK}) == '0)
               r.mode = MODE_QUERY;
            req_valid   <= 1'b1;
            req_payload <= r;
            @(posedge clock);
            while (req_stall) @(posedge clock);
            count--;
         end
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 10);
         if (count == 0 || gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window(input logic idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_WINDOW_LOW) win_low = value;
      else win_high = value;
   endtask

   task automatic set_window(input logic [CSR_W-1:0] lo, input logic [CSR_W-1:0] hi);
      wait_drained();
      write_window(CSR_WINDOW_LOW, lo);
      write_window(CSR_WINDOW_HIGH, hi);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_WINDOW_LOW;
      csr_write_data   = '0;
      traffic          = TRAFFIC_MIXED;
      win_low          = WINDOW_LOW_RESET;
      win_high         = WINDOW_HIGH_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window: set, masked matches, zero key, window edges, window before flags
      fixed_q.push_back(req_of(MODE_SET,       32'h0000_1000, 16'hFFFF));
      fixed_q.push_back(req_of(MODE_QUERY,     32'h0000_1001, 16'h0000));
      fixed_q.push_back(req_of(MODE_QUERY_ALT, 32'h2000_1000, 16'hFFFF));
      fixed_q.push_back(req_of(MODE_CLEAR,     32'h0000_1000, 16'h0000));
      fixed_q.push_back(req_of(MODE_CLEAR,     32'h0000_1000, 16'h5A5A));
      fixed_q.push_back(req_of(MODE_QUERY,     32'h0000_1000, 16'h0000));
      fixed_q.push_back(req_of(MODE_SET,       32'h0000_0000, 16'h1234));
      fixed_q.push_back(req_of(MODE_QUERY,     32'h0000_0001, 16'h0000));
      fixed_q.push_back(req_of(MODE_CLEAR,     32'h0000_0000, 16'h0000));
      fixed_q.push_back(req_of(MODE_SET,       32'h5FFF_FFFF, 16'h0000));
      fixed_q.push_back(req_of(MODE_QUERY,     32'h6000_0000, 16'hFFFF));
      fixed_q.push_back(req_of(MODE_SET,       32'hFFFF_FFFF, 16'hA5A5));
      fixed_q.push_back(req_of(MODE_CLEAR,     32'h5FFF_FFFE, 16'hFFFF));
      fixed_q.push_back(req_of(MODE_SET,       32'h0000_0005, 16'h8001));
      fixed_q.push_back(req_of(MODE_CLEAR,     32'h0000_0005, 16'h0000));
      pump(fixed_q.size() + 70);

      // flags reachable below the window
      set_window(32'h0000_0020, 32'h7FFF_FFFF);
      fixed_q.push_back(req_of(MODE_SET,       32'd0,  16'h0000));
      fixed_q.push_back(req_of(MODE_SET,       32'd14, 16'hFFFF));
      fixed_q.push_back(req_of(MODE_QUERY,     32'd14, 16'h0000));
      fixed_q.push_back(req_of(MODE_CLEAR,     32'd14, 16'h0000));
      fixed_q.push_back(req_of(MODE_QUERY,     32'd14, 16'h0000));
      fixed_q.push_back(req_of(MODE_QUERY,     32'd15, 16'h0000));
      fixed_q.push_back(req_of(MODE_QUERY,     32'd0,  16'h0000));
      fixed_q.push_back(req_of(MODE_QUERY_ALT, 32'd0,  16'h0000));
      pump(fixed_q.size() + 70);

      // whole address space: fill past capacity, mix, then free everything known
      set_window('0, '1);
      traffic = TRAFFIC_FILL;
      pump(SLOTS + 2);
      traffic = TRAFFIC_MIXED;
      pump(40);
      traffic = TRAFFIC_DRAIN;
      pump(set_addresses.size());
      traffic = TRAFFIC_MIXED;

      // empty window: flags and unsupported only
      set_window('1, '0);
      pump(50);

      // single address window
      set_window(32'h2000_0ABC, 32'h2000_0ABC);
      pump(50);

      set_window(32'h1000_0000, 32'h1000_FFFF);
      pump(70);

      wait_drained();
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[breakpoint_table_manager.f]
rtl/btm_pkg.sv
rtl/btm_ctrl.sv
rtl/btm_datapath.sv
rtl/breakpoint_table_manager.sv
rtl/btm_checker.sv
tb/sv/breakpoint_table_checker.sv
tb/sv/tb_breakpoint_table_manager.sv
